[rtl/bse_pkg.sv]
package bse_pkg;

	localparam int MAX_ORDER = 8;
	localparam int FRAC_BITS = 15;
	localparam int IDX_W     = 3;
	localparam int GRID_AW   = 2 * IDX_W;
	localparam int GRID_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int COORD_W   = 16;
	localparam int PT_W      = 3 * COORD_W;
	localparam int PW_W      = 24;   // powers and basis products
	localparam int WGT_W     = 29;   // basis weights
	localparam int MQ_W      = 30;   // shared rounding multiplier operand width
	localparam int TERM_W    = MQ_W + COORD_W;
	localparam int ACC_W     = FRAC_BITS + 33;

	localparam logic signed [ACC_W-1:0] WCAP = {1'b0, {(ACC_W-1){1'b1}}};

	localparam logic REG_SIZE_U = 1'b0;
	localparam logic REG_SIZE_V = 1'b1;

	typedef logic signed [PW_W-1:0]  pw_t;
	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef wgt_t [MAX_ORDER-1:0]    wgt_vec_t;

	// binomial coefficients, index n*8+k
	localparam logic [5:0] BINOM [GRID_DEPTH] = '{
		6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd2, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd3, 6'd3, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd4, 6'd6, 6'd4, 6'd1, 6'd0, 6'd0, 6'd0,
		6'd1, 6'd5, 6'd10, 6'd10, 6'd5, 6'd1, 6'd0, 6'd0,
		6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6, 6'd1, 6'd0,
		6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1
	};

	// sign-magnitude product, >> FRAC_BITS, round half away from zero
	function automatic logic signed [MQ_W-1:0] mulq(input logic signed [MQ_W-1:0] a,
			input logic signed [MQ_W-1:0] b);
		logic [MQ_W-1:0]   ma;
		logic [MQ_W-1:0]   mb;
		logic [2*MQ_W-1:0] p;
		logic [MQ_W-1:0]   m;
		ma = a[MQ_W-1] ? MQ_W'(-a) : MQ_W'(a);
		mb = b[MQ_W-1] ? MQ_W'(-b) : MQ_W'(b);
		p  = (2*MQ_W)'(ma) * (2*MQ_W)'(mb);
		p  = p + ((2*MQ_W)'(1) << (FRAC_BITS - 1));
		m  = MQ_W'(p >> FRAC_BITS);
		return (a[MQ_W-1] ^ b[MQ_W-1]) ? $signed(-m) : $signed(m);
	endfunction

endpackage

[rtl/bse_ram.sv]
module bse_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/bse_basis.sv]
module bse_basis (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [16:0]        t,
	input  logic [bse_pkg::IDX_W-1:0] n,
	output logic                      busy,
	output bse_pkg::wgt_vec_t         w
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_POW   = 2'd1;
	localparam logic [1:0] ST_WGT   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;
	localparam bse_pkg::pw_t ONE = bse_pkg::PW_W'(1) <<< bse_pkg::FRAC_BITS;

	logic [1:0]                  state_q;
	logic [bse_pkg::IDX_W-1:0]   cnt_q;
	logic [bse_pkg::IDX_W-1:0]   n_q;
	bse_pkg::pw_t                t_q;
	bse_pkg::pw_t                s_q;
	bse_pkg::pw_t                tp_q [bse_pkg::MAX_ORDER];
	bse_pkg::pw_t                sp_q [bse_pkg::MAX_ORDER];
	bse_pkg::pw_t                x_s1;
	logic [bse_pkg::IDX_W-1:0]   k_s1;
	logic                        v_s1;
	bse_pkg::wgt_vec_t           w_q;
	logic [bse_pkg::IDX_W-1:0]   prev;
	bse_pkg::pw_t                tp_nxt;
	bse_pkg::pw_t                sp_nxt;
	bse_pkg::pw_t                x_nxt;
	logic [5:0]                  bc;
	bse_pkg::wgt_t               w_nxt;

	assign prev   = cnt_q - 1'b1;
	assign tp_nxt = bse_pkg::PW_W'(bse_pkg::mulq(bse_pkg::MQ_W'(tp_q[prev]), bse_pkg::MQ_W'(t_q)));
	assign sp_nxt = bse_pkg::PW_W'(bse_pkg::mulq(bse_pkg::MQ_W'(sp_q[prev]), bse_pkg::MQ_W'(s_q)));
	assign x_nxt  = bse_pkg::PW_W'(bse_pkg::mulq(bse_pkg::MQ_W'(tp_q[cnt_q]),
		bse_pkg::MQ_W'(sp_q[n_q - cnt_q])));
	assign bc     = bse_pkg::BINOM[{n_q, k_s1}];
	assign w_nxt  = bse_pkg::WGT_W'(x_s1) * bse_pkg::WGT_W'($signed({1'b0, bc}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= (n == '0) ? '0 : bse_pkg::IDX_W'(1);
						state_q <= (n == '0) ? ST_WGT : ST_POW;
					end
				end
				ST_POW: begin
					if (cnt_q == n_q) begin
						cnt_q   <= '0;
						state_q <= ST_WGT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WGT: begin
					v_s1 <= 1'b1;
					if (cnt_q == n_q) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			n_q      <= n;
			t_q      <= bse_pkg::PW_W'(t);
			s_q      <= bse_pkg::PW_W'(18'sd32768 - 18'(t));
			tp_q[0]  <= ONE;
			sp_q[0]  <= ONE;
		end
		if (state_q == ST_POW) begin
			tp_q[cnt_q] <= tp_nxt;
			sp_q[cnt_q] <= sp_nxt;
		end
		if (state_q == ST_WGT) begin
			x_s1 <= x_nxt;
			k_s1 <= cnt_q;
		end
		if (v_s1) begin
			w_q[k_s1] <= w_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign w    = w_q;

endmodule

[rtl/bezier_surface_eval_core.sv]
// Load request: written to the grid memory in the accept cycle; no result.
// Evaluate request: one request at a time; the next is taken in the cycle after the result is
// loaded for output; the single multiply-accumulate lane takes the grid terms in turn.
// Out-of-range u: zero result, no basis work. A finished result may wait while a request is taken.
// Reset clears control state and sets size_u and size_v to 4; the grid is undefined until loaded.
module bezier_surface_eval_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [2:0]         row,
	input  logic [2:0]         col,
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  logic signed [15:0] pz,
	input  logic signed [16:0] u_pos,
	input  logic [15:0]        v_pos,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sx,
	output logic signed [15:0] sy,
	output logic signed [15:0] sz
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BASIS = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam int IW = bse_pkg::IDX_W;
	localparam int CW = bse_pkg::COORD_W;
	localparam int AW = bse_pkg::ACC_W;

	logic [2:0]    state_q;
	logic [3:0]    size_u_q;
	logic [3:0]    size_v_q;
	logic [IW-1:0] nu_m1;
	logic [IW-1:0] nv_m1;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic          accept;
	logic          ram_we;
	logic          eval_go;
	logic          u_bad;
	logic          out_load;
	logic          busy_u;
	logic          busy_v;
	bse_pkg::wgt_vec_t wu;
	bse_pkg::wgt_vec_t wv;
	logic [bse_pkg::PT_W-1:0] rdata;

	logic                      vld_s1;
	logic                      vld_s2;
	logic                      vld_s3;
	bse_pkg::wgt_t             wu_s1;
	bse_pkg::wgt_t             wv_s1;
	logic signed [bse_pkg::MQ_W-1:0]   pw_s2;
	logic [bse_pkg::PT_W-1:0]          pt_s2;
	logic signed [bse_pkg::TERM_W-1:0] term_s3 [3];
	logic signed [AW-1:0]              acc_q [3];
	logic signed [CW-1:0]              res [3];

	function automatic logic [IW-1:0] clamp_m1(input logic [3:0] s);
		if (s == 4'd0) begin
			return '0;
		end else if (s > 4'(bse_pkg::MAX_ORDER)) begin
			return IW'(bse_pkg::MAX_ORDER - 1);
		end
		return IW'(s - 4'd1);
	endfunction

	function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
			input logic signed [bse_pkg::TERM_W-1:0] b);
		logic signed [AW:0] s;
		s = (AW+1)'(a) + (AW+1)'(b);
		if (s > (AW+1)'(bse_pkg::WCAP)) begin
			return bse_pkg::WCAP;
		end else if (s < -(AW+1)'(bse_pkg::WCAP)) begin
			return -bse_pkg::WCAP;
		end
		return AW'(s);
	endfunction

	function automatic logic signed [CW-1:0] finish(input logic signed [AW-1:0] a);
		logic [AW-1:0] mag;
		logic [AW-1:0] r;
		mag = a[AW-1] ? AW'(-a) : AW'(a);
		r   = (mag + (AW'(1) << (bse_pkg::FRAC_BITS - 1))) >> bse_pkg::FRAC_BITS;
		if (!a[AW-1]) begin
			return (r > AW'(32767)) ? 16'sh7fff : $signed(r[CW-1:0]);
		end
		return (r > AW'(32768)) ? 16'sh8000 : $signed(-r[CW-1:0]);
	endfunction

	assign nu_m1    = clamp_m1(size_u_q);
	assign nv_m1    = clamp_m1(size_v_q);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign ram_we   = accept && !req_type;
	assign u_bad    = u_pos[16] || (u_pos > 17'sd32768);
	assign eval_go  = accept && req_type && !u_bad;
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	bse_ram #(
		.WIDTH(bse_pkg::PT_W),
		.DEPTH(bse_pkg::GRID_DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr({row, col}),
		.wdata({px, py, pz}),
		.raddr({i_q, j_q}),
		.rdata(rdata)
	);

	bse_basis u_basis_u (
		.clk   (clk),
		.arst_n(arst_n),
		.start (eval_go),
		.t     (u_pos),
		.n     (nu_m1),
		.busy  (busy_u),
		.w     (wu)
	);

	bse_basis u_basis_v (
		.clk   (clk),
		.arst_n(arst_n),
		.start (eval_go),
		.t     ($signed({1'b0, v_pos})),
		.n     (nv_m1),
		.busy  (busy_v),
		.w     (wv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			size_u_q  <= 4'd4;
			size_v_q  <= 4'd4;
			i_q       <= '0;
			j_q       <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					bse_pkg::REG_SIZE_U: size_u_q <= cfg_data;
					bse_pkg::REG_SIZE_V: size_v_q <= cfg_data;
					default: ;
				endcase
			end
			vld_s1 <= 1'b0;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= u_bad ? ST_OUT : ST_BASIS;
					end
				end
				ST_BASIS: begin
					if (!busy_u && !busy_v) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					vld_s1 <= 1'b1;
					if (j_q == nv_m1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q == nu_m1) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2 && !vld_s3) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wu_s1 <= wu[i_q];
		wv_s1 <= wv[j_q];
		pw_s2 <= bse_pkg::mulq(bse_pkg::MQ_W'(wu_s1), bse_pkg::MQ_W'(wv_s1));
		pt_s2 <= rdata;
		for (int c = 0; c < 3; c++) begin
			term_s3[c] <= bse_pkg::TERM_W'(pw_s2) *
				bse_pkg::TERM_W'($signed(pt_s2[(2-c)*CW +: CW]));
		end
		if (accept && req_type) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
			end
		end else if (vld_s3) begin
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= sat_add(acc_q[c], term_s3[c]);
			end
		end
		if (out_load) begin
			sx <= res[0];
			sy <= res[1];
			sz <= res[2];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			res[c] = finish(acc_q[c]);
		end
	end

	a_ram_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("grid write outside idle");

	a_mac_basis_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (!busy_u && !busy_v))
		else $error("accumulate while basis busy");

	a_pipe_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (state_q == ST_MAC || state_q == ST_DRAIN))
		else $error("accumulate outside evaluation");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside output state");

endmodule

[sim/bse_checker.sv]
module bse_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               req_type,
	input  logic [2:0]         row,
	input  logic [2:0]         col,
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  logic signed [15:0] pz,
	input  logic signed [16:0] u_pos,
	input  logic [15:0]        v_pos,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sx,
	input  logic signed [15:0] sy,
	input  logic signed [15:0] sz,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	localparam longint WCAP_L = (longint'(1) <<< (bse_pkg::FRAC_BITS + 32)) - 1;

	point_t             expected_pts[$];
	logic signed [15:0] grid_x[bse_pkg::GRID_DEPTH];
	logic signed [15:0] grid_y[bse_pkg::GRID_DEPTH];
	logic signed [15:0] grid_z[bse_pkg::GRID_DEPTH];
	logic [3:0]         rows_used;
	logic [3:0]         cols_used;

	initial begin
		errors  = 0;
		pending = 0;
		for (int i = 0; i < bse_pkg::GRID_DEPTH; i++) begin
			grid_x[i] = '0;
			grid_y[i] = '0;
			grid_z[i] = '0;
		end
	end

	// magnitude product, round half away from zero, capped at WCAP
	function automatic longint mul_round(longint a, longint b, int sh);
		logic [127:0] p;
		longint ua, ub, m;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = 128'(ua) * 128'(ub);
		if (sh > 0)
			p = (p + (128'(1) << (sh - 1))) >> sh;
		m = (p > 128'(WCAP_L)) ? WCAP_L : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > WCAP_L) s = WCAP_L;
		if (s < -WCAP_L) s = -WCAP_L;
		return s;
	endfunction

	function automatic int clamp_len(logic [3:0] r);
		if (r < 1) return 1;
		if (r > bse_pkg::MAX_ORDER) return bse_pkg::MAX_ORDER;
		return int'(r);
	endfunction

	function automatic void bernstein(longint t, int cnt,
			output longint w[bse_pkg::MAX_ORDER]);
		longint one, s, tp, sp;
		longint c[bse_pkg::MAX_ORDER];
		int n;
		one = longint'(1) <<< bse_pkg::FRAC_BITS;
		s = one - t;
		n = cnt - 1;
		for (int i = 0; i < bse_pkg::MAX_ORDER; i++) begin
			c[i] = 1;
			w[i] = 0;
		end
		for (int i = 1; i <= n; i++)
			for (int k = i - 1; k > 0; k--)
				c[k] = c[k] + c[k - 1];
		for (int k = 0; k <= n; k++) begin
			tp = one;
			sp = one;
			for (int i = 0; i < k; i++) tp = mul_round(tp, t, bse_pkg::FRAC_BITS);
			for (int i = 0; i < n - k; i++) sp = mul_round(sp, s, bse_pkg::FRAC_BITS);
			w[k] = mul_round(mul_round(tp, sp, bse_pkg::FRAC_BITS), c[k], 0);
		end
	endfunction

	function automatic logic signed [15:0] to_coord(longint acc);
		longint r;
		r = mul_round(acc, 1, bse_pkg::FRAC_BITS);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic point_t surface_point(logic signed [16:0] u, logic [15:0] v);
		longint wu[bse_pkg::MAX_ORDER], wv[bse_pkg::MAX_ORDER];
		longint ax, ay, az, w;
		int nu, nv, a;
		point_t p;
		p = '0;
		if (u < 0 || u > 32768)
			return p;
		nu = clamp_len(rows_used);
		nv = clamp_len(cols_used);
		bernstein(longint'(u), nu, wu);
		bernstein(longint'(v), nv, wv);
		ax = 0;
		ay = 0;
		az = 0;
		for (int i = 0; i < nu; i++)
			for (int j = 0; j < nv; j++) begin
				w = mul_round(wu[i], wv[j], bse_pkg::FRAC_BITS);
				a = i * bse_pkg::MAX_ORDER + j;
				ax = sat_add(ax, mul_round(w, longint'(grid_x[a]), 0));
				ay = sat_add(ay, mul_round(w, longint'(grid_y[a]), 0));
				az = sat_add(az, mul_round(w, longint'(grid_z[a]), 0));
			end
		p.x = to_coord(ax);
		p.y = to_coord(ay);
		p.z = to_coord(az);
		return p;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			rows_used = 4;
			cols_used = 4;
			expected_pts.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == bse_pkg::REG_SIZE_U) rows_used = cfg_data;
				else cols_used = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_pts.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = expected_pts.pop_front();
					if (sx !== want.x) report("sx", sx, want.x);
					if (sy !== want.y) report("sy", sy, want.y);
					if (sz !== want.z) report("sz", sz, want.z);
				end
			end
			if (in_valid && in_ready) begin
				if (req_type) begin
					expected_pts.insert(expected_pts.size(), surface_point(u_pos, v_pos));
				end else begin
					grid_x[{row, col}] = px;
					grid_y[{row, col}] = py;
					grid_z[{row, col}] = pz;
				end
			end
		end
		pending = expected_pts.size();
	end

endmodule

[sim/bezier_surface_eval_core_tb.sv]
module bezier_surface_eval_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_idx = 0;
	logic [3:0]         cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic               req_type = 0;
	logic [2:0]         row = '0;
	logic [2:0]         col = '0;
	logic signed [15:0] px = '0;
	logic signed [15:0] py = '0;
	logic signed [15:0] pz = '0;
	logic signed [16:0] u_pos = '0;
	logic [15:0]        v_pos = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] sx;
	logic signed [15:0] sy;
	logic signed [15:0] sz;
	int                 errors;
	int                 pending;

	logic quiet_tx = 0;
	logic quiet_rx = 0;
	logic hold_req = 0;
	logic hold_done = 0;
	int   stall = 0;

	always #2 clk = ~clk;

	bezier_surface_eval_core u_top (.*);

	bse_checker u_chk (.*);

	// output side: random back-pressure, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_ready <= 0;
			stall     <= 0;
			hold_done <= 0;
		end else if (stall > 0) begin
			out_ready <= 0;
			stall     <= stall - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 0;
			stall     <= 400;
			hold_done <= 1;
		end else begin
			r = $urandom_range(0, 99);
			if (quiet_rx || r < 70) begin
				out_ready <= 1;
			end else begin
				out_ready <= 0;
				stall     <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
			end
		end
	end

	function automatic int tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_tx || r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(logic t, logic [2:0] r, logic [2:0] c, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, logic signed [16:0] u,
			logic [15:0] v);
		int g;
		g = tx_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= t;
		row      <= r;
		col      <= c;
		px       <= x;
		py       <= y;
		pz       <= z;
		u_pos    <= u;
		v_pos    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_pt(int r, int c, int x, int y, int z);
		send(1'b0, 3'(r), 3'(c), 16'(x), 16'(y), 16'(z), 17'($urandom), 16'($urandom));
	endtask

	task automatic eval_at(int u, int v);
		send(1'b1, 3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 17'(u), 16'(v));
	endtask

	task automatic write_size(logic idx, logic [3:0] val);
		in_valid <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic int rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return -32768;
		if (r < 10) return 32767;
		if (r < 13) return 0;
		return $signed(16'($urandom));
	endfunction

	function automatic int rand_u();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return 32768;
		if (r < 85) return $urandom_range(0, 32768);
		return $signed(17'($urandom));
	endfunction

	function automatic int rand_v();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return 32768;
		if (r < 82) return $urandom_range(0, 32768);
		return $urandom_range(0, 65535);
	endfunction

	initial begin
		logic [3:0] su_list[7] = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd8, 4'd2, 4'd15};
		logic [3:0] sv_list[7] = '{4'd1, 4'd8, 4'd15, 4'd5, 4'd1, 4'd8, 4'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// whole grid written before any evaluate reads it
		for (int i = 0; i < bse_pkg::GRID_DEPTH; i++)
			load_pt(i / bse_pkg::MAX_ORDER, i % bse_pkg::MAX_ORDER,
				rand_coord(), rand_coord(), rand_coord());

		load_pt(0, 0, 32767, -32768, 0);
		load_pt(3, 3, -32768, 32767, -1);
		load_pt(7, 7, 32767, 32767, 32767);
		load_pt(0, 3, -32768, -32768, -32768);
		eval_at(0, 0);
		eval_at(32768, 32768);
		eval_at(32768, 0);
		eval_at(0, 32768);
		eval_at(16384, 16384);
		eval_at(1, 32767);
		eval_at(-1, 100);
		eval_at(32769, 100);
		eval_at(-65536, 0);
		eval_at(65535, 0);
		eval_at(16384, 65535);
		eval_at(20000, 40000);
		load_pt(1, 2, 12345, -54, 7);
		eval_at(8192, 24576);

		for (int ph = 0; ph < 7; ph++) begin
			write_size(bse_pkg::REG_SIZE_U, su_list[ph]);
			write_size(bse_pkg::REG_SIZE_V, sv_list[ph]);
			quiet_tx = (ph == 3);
			quiet_rx = (ph == 3 || ph == 5);
			for (int n = 0; n < 200; n++) begin
				if (ph == 1 && n == 50)
					hold_req <= 1;
				if ($urandom_range(0, 99) < 30)
					load_pt($urandom_range(0, 7), $urandom_range(0, 7),
						rand_coord(), rand_coord(), rand_coord());
				else
					eval_at(rand_u(), rand_v());
			end
		end
		write_size(bse_pkg::REG_SIZE_U, 4'd4);
		write_size(bse_pkg::REG_SIZE_V, 4'd4);
		for (int n = 0; n < 20; n++)
			eval_at(rand_u(), rand_v());

		in_valid <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("PASS bezier_surface_eval_core");
		else
			$display("FAIL bezier_surface_eval_core");
		$finish;
	end

	initial begin
		#8ms;
		$display("FAIL bezier_surface_eval_core");
		$finish;
	end

endmodule

[sim.f]
rtl/bse_pkg.sv
rtl/bse_ram.sv
rtl/bse_basis.sv
rtl/bezier_surface_eval_core.sv
sim/bse_checker.sv
sim/bezier_surface_eval_core_tb.sv
